[rtl/core/sha256_message_hasher_core_macros.svh]
// ----------------------------------------------------------------------------
// SHA-256 message hasher assertion macros
// Shorthand for clocked, reset-gated concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef SHA256_MESSAGE_HASHER_CORE_MACROS_SVH
`define SHA256_MESSAGE_HASHER_CORE_MACROS_SVH

// property holds on every clock outside reset
`define SHAMH_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define SHAMH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/shamh_pkg.sv]
// ----------------------------------------------------------------------------
// SHA-256 hasher package
// Shared types, round constants and initial hash value.
// ----------------------------------------------------------------------------
`default_nettype none

package shamh_pkg;

    typedef logic [0:7][31:0] hw_t;

    typedef struct packed {
        logic       shift_en;
        logic [7:0] shift_byte;
        logic       start;
        logic       init;
    } cmp_ctl_t;

    localparam hw_t IV_HASH = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [0:63][31:0] ROUND_K = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

`default_nettype wire

[rtl/core/shamh_round.sv]
// ----------------------------------------------------------------------------
// SHA-256 round unit
// One compression round and one message schedule word, combinational.
// ----------------------------------------------------------------------------
`default_nettype none

module shamh_round (
    input  shamh_pkg::hw_t rw,
    input  logic [31:0]    k,
    input  logic [31:0]    w0,
    input  logic [31:0]    w1,
    input  logic [31:0]    w9,
    input  logic [31:0]    w14,
    output shamh_pkg::hw_t rw_new,
    output logic [31:0]    w_new
);

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    logic [31:0] a;
    logic [31:0] e;
    logic [31:0] big_s0;
    logic [31:0] big_s1;
    logic [31:0] ch;
    logic [31:0] maj;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] sm_s0;
    logic [31:0] sm_s1;

    assign a      = rw[0];
    assign e      = rw[4];
    assign big_s0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
    assign big_s1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
    assign ch     = (e & rw[5]) ^ (~e & rw[6]);
    assign maj    = (a & rw[1]) ^ (a & rw[2]) ^ (rw[1] & rw[2]);
    assign t1     = rw[7] + big_s1 + ch + k + w0;
    assign t2     = big_s0 + maj;

    assign rw_new = {t1 + t2, rw[0], rw[1], rw[2], rw[3] + t1, rw[4], rw[5], rw[6]};

    assign sm_s0 = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
    assign sm_s1 = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
    assign w_new = w0 + sm_s0 + w9 + sm_s1;

endmodule

`default_nettype wire

[rtl/core/shamh_out.sv]
// ----------------------------------------------------------------------------
// SHA-256 digest output stage
// Holds a finished digest and sends it one word per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module shamh_out (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  shamh_pkg::hw_t digest_in,
    input  logic           dig_stall,
    output logic           dig_valid,
    output logic [31:0]    digest_word,
    output logic [2:0]     word_index,
    output logic           last,
    output logic           busy
);

    logic           vld_reg;
    logic           vld_next;
    logic [2:0]     idx_reg;
    logic [2:0]     idx_next;
    shamh_pkg::hw_t dig_reg;
    shamh_pkg::hw_t dig_next;

    always_comb
    begin
        vld_next = vld_reg;
        idx_next = idx_reg;
        dig_next = dig_reg;
        if (load)
        begin
            vld_next = 1'b1;
            idx_next = 3'd0;
            dig_next = digest_in;
        end
        else if (vld_reg && !dig_stall)
        begin
            idx_next = idx_reg + 3'd1;
            dig_next = {dig_reg[1:7], 32'h0};
            if (idx_reg == 3'd7)
            begin
                vld_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
            idx_reg <= 3'd0;
        end
        else
        begin
            vld_reg <= vld_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg <= dig_next;
    end

    assign dig_valid   = vld_reg;
    assign digest_word = dig_reg[0];
    assign word_index  = idx_reg;
    assign last        = (idx_reg == 3'd7);
    assign busy        = vld_reg;

endmodule

`default_nettype wire

[rtl/core/shamh_compress.sv]
// ----------------------------------------------------------------------------
// SHA-256 compression sequencer
// Message window, working words and hash state; one round per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module shamh_compress (
    input  logic                clk,
    input  logic                rst_n,
    input  shamh_pkg::cmp_ctl_t ctl,
    output logic                done,
    output shamh_pkg::hw_t      hash
);

    typedef enum logic [1:0] {
        C_IDLE,
        C_ROUND,
        C_FOLD
    } cstate_t;

    cstate_t        state_reg;
    cstate_t        state_next;
    logic [5:0]     rnd_reg;
    logic [5:0]     rnd_next;
    shamh_pkg::hw_t hash_reg;
    shamh_pkg::hw_t hash_next;
    shamh_pkg::hw_t rw_reg;
    shamh_pkg::hw_t rw_next;
    logic [511:0]   win_reg;
    logic [511:0]   win_next;
    shamh_pkg::hw_t rw_new;
    logic [31:0]    w_new;

    shamh_round u_round (
        .rw     (rw_reg),
        .k      (shamh_pkg::ROUND_K[rnd_reg]),
        .w0     (win_reg[511:480]),
        .w1     (win_reg[479:448]),
        .w9     (win_reg[223:192]),
        .w14    (win_reg[63:32]),
        .rw_new (rw_new),
        .w_new  (w_new)
    );

    always_comb
    begin
        state_next = state_reg;
        rnd_next   = rnd_reg;
        hash_next  = hash_reg;
        rw_next    = rw_reg;
        win_next   = win_reg;
        unique case (state_reg)
            C_IDLE:
            begin
                if (ctl.init)
                begin
                    hash_next = shamh_pkg::IV_HASH;
                end
                if (ctl.shift_en)
                begin
                    win_next = {win_reg[503:0], ctl.shift_byte};
                end
                if (ctl.start)
                begin
                    rw_next    = hash_reg;
                    rnd_next   = 6'd0;
                    state_next = C_ROUND;
                end
            end
            C_ROUND:
            begin
                rw_next  = rw_new;
                win_next = {win_reg[479:0], w_new};
                rnd_next = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                begin
                    state_next = C_FOLD;
                end
            end
            C_FOLD:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    hash_next[i] = hash_reg[i] + rw_reg[i];
                end
                state_next = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            rnd_reg   <= 6'd0;
            hash_reg  <= shamh_pkg::IV_HASH;
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
            hash_reg  <= hash_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rw_reg  <= rw_next;
        win_reg <= win_next;
    end

    assign done = (state_reg == C_FOLD);
    assign hash = hash_reg;

endmodule

`default_nettype wire

[rtl/core/sha256_message_hasher_core.sv]
// ----------------------------------------------------------------------------
// SHA-256 message hasher core
// Absorbs a message one byte per beat, pads on finish, sends the digest.
//
//   channel  dir  signals                                    beat
//   msg      in   msg_valid msg_stall op data_byte           one byte or finish
//   dig      out  dig_valid dig_stall digest_word word_index last  one word
//
// A data byte that does not fill a block causes no stall; the byte that fills
// a block stalls the input through 64 rounds of the shared round unit, then the hash fold.
// A finish feeds 9 to 72 padding bytes through the same byte path, one per
// cycle outside the compressions, runs one or two compressions, hands the
// digest to the output register; the eight words drain at dig_stall's pace.
// Reset restores the initial hash value and clears the byte count.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_message_hasher_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        msg_valid,
    output logic        msg_stall,
    input  logic        op,
    input  logic [7:0]  data_byte,
    output logic        dig_valid,
    input  logic        dig_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PAD,
        S_HASH,
        S_EMIT
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    state_t              ret_reg;
    state_t              ret_next;
    logic [63:0]         cnt_reg;
    logic [63:0]         cnt_next;
    logic [63:0]         len_reg;
    logic [63:0]         len_next;
    logic                first_reg;
    logic                first_next;
    logic                extra_reg;
    logic                extra_next;
    logic [5:0]          pos;
    logic                acc;
    logic                len_phase;
    logic [7:0]          pad_byte;
    logic                out_load;
    logic                out_busy;
    logic                cmp_done;
    shamh_pkg::cmp_ctl_t ctl;
    shamh_pkg::hw_t      hash;

    shamh_compress u_compress (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .done  (cmp_done),
        .hash  (hash)
    );

    shamh_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (out_load),
        .digest_in   (hash),
        .dig_stall   (dig_stall),
        .dig_valid   (dig_valid),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last        (last),
        .busy        (out_busy)
    );

    assign pos       = cnt_reg[5:0];
    assign msg_stall = (state_reg != S_IDLE);
    assign acc       = msg_valid && !msg_stall;
    assign len_phase = !first_reg && !extra_reg && (pos[5:3] == 3'b111);

    always_comb
    begin
        if (first_reg)
        begin
            pad_byte = 8'h80;
        end
        else if (len_phase)
        begin
            pad_byte = len_reg[63:56];
        end
        else
        begin
            pad_byte = 8'h00;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        cnt_next   = cnt_reg;
        len_next   = len_reg;
        first_next = first_reg;
        extra_next = extra_reg;
        out_load   = 1'b0;
        ctl        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    if (!op)
                    begin
                        ctl.shift_en   = 1'b1;
                        ctl.shift_byte = data_byte;
                        cnt_next       = cnt_reg + 64'd1;
                        if (&pos)
                        begin
                            ctl.start  = 1'b1;
                            ret_next   = S_IDLE;
                            state_next = S_HASH;
                        end
                    end
                    else
                    begin
                        len_next   = {cnt_reg[60:0], 3'b000};
                        first_next = 1'b1;
                        extra_next = (pos[5:3] == 3'b111);
                        state_next = S_PAD;
                    end
                end
            end
            S_PAD:
            begin
                ctl.shift_en   = 1'b1;
                ctl.shift_byte = pad_byte;
                cnt_next       = cnt_reg + 64'd1;
                first_next     = 1'b0;
                if (len_phase)
                begin
                    len_next = {len_reg[55:0], 8'h00};
                end
                if (&pos)
                begin
                    ctl.start  = 1'b1;
                    extra_next = 1'b0;
                    ret_next   = extra_reg ? S_PAD : S_EMIT;
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                if (cmp_done)
                begin
                    state_next = ret_reg;
                end
            end
            S_EMIT:
            begin
                if (!out_busy)
                begin
                    out_load   = 1'b1;
                    ctl.init   = 1'b1;
                    cnt_next   = 64'd0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
            cnt_reg   <= 64'd0;
            first_reg <= 1'b0;
            extra_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            cnt_reg   <= cnt_next;
            first_reg <= first_next;
            extra_reg <= extra_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
    end

endmodule

`default_nettype wire

[rtl/core/shamh_checker.sv]
// ----------------------------------------------------------------------------
// SHA-256 hasher port checker
// Watches the top-level ports for digest sequencing and handshake slips.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sha256_message_hasher_core_macros.svh"

module shamh_checker (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        msg_valid,
    input  wire        msg_stall,
    input  wire        op,
    input  wire        dig_valid,
    input  wire        dig_stall,
    input  wire [31:0] digest_word,
    input  wire [2:0]  word_index,
    input  wire        last
);

    `SHAMH_ASSERT_NEXT(a_dig_hold, dig_valid && dig_stall, dig_valid && $stable(digest_word) && $stable(word_index), "stalled digest beat changed")
    `SHAMH_ASSERT_NEXT(a_dig_seq, dig_valid && !dig_stall && !last, dig_valid && (word_index == $past(word_index) + 3'd1), "digest words out of sequence")
    `SHAMH_ASSERT(a_last_idx, !dig_valid || (last == (word_index == 3'd7)), "last flag not on final word")
    `SHAMH_ASSERT_NEXT(a_fin_stall, msg_valid && !msg_stall && op, msg_stall, "input not stalled after finish")

endmodule

bind sha256_message_hasher_core shamh_checker u_shamh_checker (.*);

`default_nettype wire

[tb/sv/sha256_message_hasher_core_tb.sv]
// ----------------------------------------------------------------------------
// SHA-256 message hasher core testbench
// Sends byte and finish beats and predicts each digest with a behavioral
// SHA-256 kept in step with the accepted beats. Every digest word is compared
// in order against the prediction, under random idle and stall bursts and a
// long output hold-off that backs the core up into its input.
// ----------------------------------------------------------------------------
module sha256_message_hasher_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic OP_DATA   = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam int BURST_MAX   = 18;
    localparam int HOLD_CYCLES = 600;
    localparam int DRAIN_CYCLES = 300;

    localparam logic [0:7][31:0] HASH_INIT = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [0:63][31:0] ROUND_CONST = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        tail;
    } digest_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        msg_valid = 1'b0;
    logic        msg_stall;
    logic        op = OP_DATA;
    logic [7:0]  data_byte = 8'h00;
    logic        dig_valid;
    logic        dig_stall = 1'b0;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last;

    logic [31:0]  hash_state [8];
    logic [7:0]   msg_block [64];
    logic [63:0]  msg_len;
    digest_beat_t expected_words [$];

    int  mismatch_count = 0;
    int  beats_sent = 0;
    int  send_gap_pct = 0;
    int  recv_gap_pct = 0;
    int  stall_left = 0;
    logic hold_on = 1'b0;
    event hold_kick;

    sha256_message_hasher_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .msg_valid   (msg_valid),
        .msg_stall   (msg_stall),
        .op          (op),
        .data_byte   (data_byte),
        .dig_valid   (dig_valid),
        .dig_stall   (dig_stall),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last        (last)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ---- SHA-256 prediction ----

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic void restart_hash();
        for (int i = 0; i < 8; i++)
            hash_state[i] = HASH_INIT[i];
        for (int i = 0; i < 64; i++)
            msg_block[i] = 8'h00;
        msg_len = 64'd0;
    endfunction

    function automatic void compress_block();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
        for (int t = 0; t < 16; t++)
            w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
        for (int t = 16; t < 64; t++)
        begin
            s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
            s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
            w[t] = w[t-16] + s0 + w[t-7] + s1;
        end
        a = hash_state[0];
        b = hash_state[1];
        c = hash_state[2];
        d = hash_state[3];
        e = hash_state[4];
        f = hash_state[5];
        g = hash_state[6];
        h = hash_state[7];
        for (int r = 0; r < 64; r++)
        begin
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
                 + ROUND_CONST[r] + w[r];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g;
            g = f;
            f = e;
            e = d + t1;
            d = c;
            c = b;
            b = a;
            a = t1 + t2;
        end
        hash_state[0] += a;
        hash_state[1] += b;
        hash_state[2] += c;
        hash_state[3] += d;
        hash_state[4] += e;
        hash_state[5] += f;
        hash_state[6] += g;
        hash_state[7] += h;
    endfunction

    function automatic void absorb_byte(input logic [7:0] value);
        msg_block[msg_len[5:0]] = value;
        msg_len = msg_len + 64'd1;
        if (msg_len[5:0] == 6'd0)
            compress_block();
    endfunction

    function automatic void finish_message();
        logic [63:0]  bit_len;
        int           pos;
        digest_beat_t beat;
        bit_len = msg_len << 3;
        pos = int'(msg_len[5:0]);
        msg_block[pos] = 8'h80;
        pos++;
        if (pos > 56)
        begin
            for (int i = pos; i < 64; i++)
                msg_block[i] = 8'h00;
            compress_block();
            pos = 0;
        end
        for (int i = pos; i < 56; i++)
            msg_block[i] = 8'h00;
        for (int i = 0; i < 8; i++)
            msg_block[56+i] = bit_len[63-8*i -: 8];
        compress_block();
        for (int i = 0; i < 8; i++)
        begin
            beat.word = hash_state[i];
            beat.index = 3'(i);
            beat.tail = (i == 7);
            expected_words.push_back(beat);
        end
        restart_hash();
    endfunction

    // ---- digest side ----

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    task automatic check_digest_beat();
        digest_beat_t want;
        if (expected_words.size() == 0)
        begin
            report_mismatch($sformatf("unexpected word %08h index %0d last %0b",
                                      digest_word, word_index, last));
            return;
        end
        want = expected_words.pop_front();
        if (digest_word !== want.word || word_index !== want.index || last !== want.tail)
            report_mismatch($sformatf(
                "word %08h (exp %08h) index %0d (exp %0d) last %0b (exp %0b)",
                digest_word, want.word, word_index, want.index, last, want.tail));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && dig_valid && !dig_stall)
            check_digest_beat();
        if (stall_left == 0 && recv_gap_pct != 0 && $urandom_range(0, 99) < recv_gap_pct)
            stall_left = $urandom_range(1, BURST_MAX);
        dig_stall <= hold_on || (stall_left != 0);
        if (stall_left != 0)
            stall_left = stall_left - 1;
    end

    // long output hold-off, counted here so the sender keeps pushing
    initial
    begin
        forever
        begin
            @(hold_kick);
            @(posedge clk);
            hold_on <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_on <= 1'b0;
        end
    end

    // ---- message side ----

    task automatic send_beat(input logic beat_op, input logic [7:0] beat_byte);
        if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct)
        begin
            msg_valid <= 1'b0;
            op <= 1'($urandom);
            data_byte <= 8'($urandom);
            repeat ($urandom_range(1, BURST_MAX)) @(posedge clk);
        end
        msg_valid <= 1'b1;
        op <= beat_op;
        data_byte <= beat_byte;
        do
            @(posedge clk);
        while (msg_stall);
        beats_sent++;
        if (beat_op == OP_FINISH)
            finish_message();
        else
            absorb_byte(beat_byte);
    endtask

    task automatic send_message(input int n_bytes);
        for (int i = 0; i < n_bytes; i++)
            send_beat(OP_DATA, 8'($urandom_range(0, 255)));
        send_beat(OP_FINISH, 8'($urandom_range(0, 255)));
    endtask

    function automatic int pick_message_length();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0: return 55;
            1: return 56;
            2: return 63;
            3: return 64;
            4: return $urandom_range(0, 2);
            5: return $urandom_range(118, 121);
            default: return $urandom_range(0, 60);
        endcase
    endfunction

    // ---- tests ----

    // empty message twice, with junk on data_byte
    task automatic test_empty_message();
        send_gap_pct = 20;
        recv_gap_pct = 20;
        send_beat(OP_FINISH, 8'hff);
        send_beat(OP_FINISH, 8'h00);
    endtask

    task automatic test_byte_extremes();
        send_beat(OP_DATA, 8'h61);
        send_beat(OP_DATA, 8'h62);
        send_beat(OP_DATA, 8'h63);
        send_beat(OP_FINISH, 8'h5a);
        send_beat(OP_DATA, 8'h00);
        send_beat(OP_DATA, 8'hff);
        send_beat(OP_DATA, 8'h80);
        send_beat(OP_DATA, 8'h7f);
        send_beat(OP_FINISH, 8'ha5);
    endtask

    // lengths cluster around the one/two padding block boundary
    task automatic test_random_messages();
        while (beats_sent < 260)
        begin
            send_gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
            recv_gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
            send_message(pick_message_length());
        end
    endtask

    task automatic test_output_backpressure();
        send_gap_pct = 0;
        recv_gap_pct = 0;
        -> hold_kick;
        repeat (3)
            send_message($urandom_range(1, 8));
    endtask

    task automatic test_back_to_back();
        send_gap_pct = 0;
        recv_gap_pct = 0;
        send_message(55);
        send_message(0);
        send_message($urandom_range(1, 10));
        send_message(1);
    endtask

    initial
    begin
        restart_hash();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_message();
        test_byte_extremes();
        test_random_messages();
        test_output_backpressure();
        test_back_to_back();

        msg_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("timeout, %0d digest words outstanding", expected_words.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/shamh_pkg.sv
rtl/core/shamh_round.sv
rtl/core/shamh_out.sv
rtl/core/shamh_compress.sv
rtl/core/sha256_message_hasher_core.sv
rtl/core/shamh_checker.sv
tb/sv/sha256_message_hasher_core_tb.sv
